@@ design/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths and the word type that the sorting cells pass to neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int OUT_W      = 33;
    localparam int MAX_WINDOW = 64;
    localparam int AGE_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = AGE_W + 1;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    // Register index of window_size.
    localparam logic REG_WINDOW_SIZE = 1'b0;

    localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(5);

    // What one cell shows its neighbors in the current cycle.
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;   // stored sample
        logic [AGE_W-1:0]    age;     // samples that arrived after this one
        logic                active;  // cell lies inside the window
        logic                gt;      // stored sample is above the incoming one
        logic                del;     // this cell holds the oldest sample
        logic                after;   // the oldest sample sits here or further left
    } swm_cell_t;

endpackage

`default_nettype wire

@@ design/swm_cell.sv @@
// ----------------------------------------------------------------------------
// Sliding window median sorting cell
// One slot of the sorted window: drops the oldest word and inserts a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
    input  wire logic                             clk,
    input  wire logic [swm_pkg::AGE_W-1:0]        idx,
    input  wire logic [swm_pkg::LEN_W-1:0]        win_len,
    input  wire logic                             clear,
    input  wire logic                             shift,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]     x,
    input  wire swm_pkg::swm_cell_t               left,
    input  wire swm_pkg::swm_cell_t               right,
    output swm_pkg::swm_cell_t                    me
);

    logic [swm_pkg::SAMPLE_W-1:0] val_reg;
    logic [swm_pkg::SAMPLE_W-1:0] val_next;
    logic [swm_pkg::AGE_W-1:0]    age_reg;
    logic [swm_pkg::AGE_W-1:0]    age_next;
    logic [swm_pkg::AGE_W-1:0]    last_age;

    logic [swm_pkg::SAMPLE_W-1:0] ri_val;
    logic [swm_pkg::AGE_W-1:0]    ri_age;
    logic                         ri_gt;
    logic [swm_pkg::SAMPLE_W-1:0] rm_val;
    logic [swm_pkg::AGE_W-1:0]    rm_age;
    logic                         rm_gt;

    assign last_age = swm_pkg::AGE_W'(win_len - swm_pkg::LEN_W'(1));

    always_comb
    begin
        me.value  = val_reg;
        me.age    = age_reg;
        me.active = {1'b0, idx} < win_len;
        me.gt     = me.active && ($signed(val_reg) > $signed(x));
        me.del    = me.active && (age_reg == last_age);
        me.after  = left.after || me.del;
    end

    // With the oldest word removed, the window shifts left from its slot on.
    // Slot i then takes the removed-window entry at i, the new word, or the
    // entry at i-1, whichever keeps the order.
    always_comb
    begin
        if (me.after)
        begin
            ri_val = right.value;
            ri_age = right.age;
            ri_gt  = right.active ? right.gt : 1'b1;
        end
        else
        begin
            ri_val = val_reg;
            ri_age = age_reg;
            ri_gt  = me.gt;
        end

        if (left.after)
        begin
            rm_val = val_reg;
            rm_age = age_reg;
            rm_gt  = me.gt;
        end
        else
        begin
            rm_val = left.value;
            rm_age = left.age;
            rm_gt  = left.gt;
        end

        if (!ri_gt)
        begin
            val_next = ri_val;
            age_next = ri_age + swm_pkg::AGE_W'(1);
        end
        else if (!rm_gt)
        begin
            val_next = x;
            age_next = '0;
        end
        else
        begin
            val_next = rm_val;
            age_next = rm_age + swm_pkg::AGE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            val_reg <= '0;
            age_reg <= idx;
        end
        else if (shift && me.active)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

`default_nettype wire

@@ design/sliding_window_median_unit.sv @@
// ----------------------------------------------------------------------------
// Sliding window median unit
// Running median of the last window_size signed samples, given as twice the
// median so that even windows come out exact.
// ----------------------------------------------------------------------------
// The unit takes one sample word per clock unless the output side stalls, and
// returns one median_twice word for each from its result register. The window
// is a row of 64 sorting cells kept in ascending order; each cell also tracks
// the age of its sample. On every accepted word the cell holding the oldest
// sample drops out and the new sample is inserted in order in the same cycle,
// with each cell looking only at its two neighbors. The result register then
// adds the two middle cells (or doubles the middle one for an odd window).
// That same-cycle insert across the row sets the rate of one word per clock.
// After reset, and for one cycle after each write of window_size, the row is
// cleared to zeros and in_ready is low. window_size lives at byte address 0;
// it keeps the low 7 bits of a write; 0 acts as 1 and values above 64 act as 64.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [swm_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [swm_pkg::DATA_W-1:0]     pwdata,
    output logic      [swm_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]   sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [swm_pkg::OUT_W-1:0]      median_twice
);

    localparam int AW = swm_pkg::AGE_W;
    localparam int NW = swm_pkg::MAX_WINDOW;

    logic [swm_pkg::LEN_W-1:0] ws_reg;
    logic [swm_pkg::LEN_W-1:0] win_len;
    logic                      cfg_we;
    logic                      clear_reg;

    // pend_reg: the cells hold a window whose median has not been taken yet.
    logic                      pend_reg;
    logic                      pend_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [swm_pkg::OUT_W-1:0] med_reg;
    logic [swm_pkg::OUT_W-1:0] med_next;
    logic                      capture;
    logic                      in_acc;

    swm_pkg::swm_cell_t        cells    [NW];
    swm_pkg::swm_cell_t        left_in  [NW];
    swm_pkg::swm_cell_t        right_in [NW];
    logic [NW-1:0]             del_vec;

    logic [AW-1:0]             mid;
    logic [AW-1:0]             lo_idx;
    logic [swm_pkg::SAMPLE_W-1:0] lo_val;
    logic [swm_pkg::SAMPLE_W-1:0] hi_val;

    // Configuration port. Writes land on the access cycle.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[swm_pkg::ADDR_W-1] == swm_pkg::REG_WINDOW_SIZE);

    always_comb
    begin
        if (paddr[swm_pkg::ADDR_W-1] == swm_pkg::REG_WINDOW_SIZE)
        begin
            prdata = {{(swm_pkg::DATA_W - swm_pkg::LEN_W){1'b0}}, ws_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg    <= swm_pkg::WINDOW_RESET;
            clear_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                ws_reg <= pwdata[swm_pkg::LEN_W-1:0];
            end
            clear_reg <= cfg_we;
        end
    end

    // Effective window length, 1 to 64.
    always_comb
    begin
        if (ws_reg == '0)
        begin
            win_len = swm_pkg::LEN_W'(1);
        end
        else if (ws_reg > swm_pkg::LEN_W'(NW))
        begin
            win_len = swm_pkg::LEN_W'(NW);
        end
        else
        begin
            win_len = ws_reg;
        end
    end

    // Handshake. A new word may enter while the previous median is captured
    // into the output register in the same cycle.
    assign capture   = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !clear_reg && (!pend_reg || capture);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign median_twice = med_reg;

    always_comb
    begin
        pend_next = in_acc || (pend_reg && !capture);
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The sorted row of cells.
    genvar g;
    generate
        for (g = 0; g < NW; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_in[g] = '0;
            end
            else
            begin : g_inner_l
                assign left_in[g] = cells[g-1];
            end

            if (g == NW - 1)
            begin : g_last
                assign right_in[g] = '0;
            end
            else
            begin : g_inner_r
                assign right_in[g] = cells[g+1];
            end

            swm_cell u_cell (
                .clk     (clk),
                .idx     (AW'(g)),
                .win_len (win_len),
                .clear   (clear_reg),
                .shift   (in_acc),
                .x       (sample),
                .left    (left_in[g]),
                .right   (right_in[g]),
                .me      (cells[g])
            );

            assign del_vec[g] = cells[g].del;
        end
    endgenerate

    // Middle taps. For an odd length both taps are the middle cell.
    assign mid    = win_len[swm_pkg::LEN_W-1:1];
    assign lo_idx = win_len[0] ? mid : (mid - AW'(1));
    assign lo_val = cells[lo_idx].value;
    assign hi_val = cells[mid].value;
    assign med_next = {lo_val[swm_pkg::SAMPLE_W-1], lo_val}
                      + {hi_val[swm_pkg::SAMPLE_W-1], hi_val};

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            med_reg <= med_next;
        end
    end

    // Exactly one cell of the window holds the oldest sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg |-> $countones(del_vec) == 1)
        else $error("oldest sample not unique in the window");

    // A stalled median blocks new words until it can move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("word accepted while the result path is full");

    // Every accepted word leaves a median waiting to be captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pend_reg)
        else $error("accepted word lost its median");

endmodule

`default_nettype wire
